// File: sv/sph_pkg.sv
`timescale 1ns / 1ps

package sph_pkg;

   localparam int WORD_W   = 64;
   localparam int COUNT_W  = 4;
   localparam int ROUNDS_W = 4;
   localparam int INDEX_W  = 3;
   localparam int LEN_W    = 8;
   localparam int LANES    = 4;
   localparam int BYTES    = WORD_W / 8;

   localparam logic [WORD_W-1:0] SIP_C0 = 64'h736f6d6570736575;
   localparam logic [WORD_W-1:0] SIP_C1 = 64'h646f72616e646f6d;
   localparam logic [WORD_W-1:0] SIP_C2 = 64'h6c7967656e657261;
   localparam logic [WORD_W-1:0] SIP_C3 = 64'h7465646279746573;

   localparam logic [LEN_W-1:0] TWEAK_WIDE   = 8'hEE;
   localparam logic [LEN_W-1:0] TWEAK_NARROW = 8'hFF;
   localparam logic [LEN_W-1:0] TWEAK_SECOND = 8'hDD;

   localparam logic [COUNT_W-1:0] FULL_COUNT = COUNT_W'(BYTES);
   localparam logic [LEN_W-1:0]   FULL_LEN   = LEN_W'(BYTES);

   typedef enum logic [INDEX_W-1:0] {
      REG_KEY_LOW         = 3'd0,
      REG_KEY_HIGH        = 3'd1,
      REG_MESSAGE_ROUNDS  = 3'd2,
      REG_FINALIZE_ROUNDS = 3'd3,
      REG_WIDE_OUTPUT     = 3'd4
   } csr_reg_type;

   typedef logic [LANES-1:0][WORD_W-1:0] lanes_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch the accepted word
      logic inject;     // open lanes if needed, xor word into lane 3
      logic len_word;   // inject the length-only word
      logic round;      // one SipRound
      logic fold;       // xor word into lane 0
      logic fin_tweak;  // lane 2 tweak ahead of finalisation
      logic cap_lo;     // capture first digest word
      logic hi_tweak;   // lane 1 tweak ahead of second digest word
      logic cap_hi;     // capture second digest word
      logic emit;       // move digest to the output register
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic                last;
      logic                full;
      logic                wide;
      logic                rsp_busy;
      logic [ROUNDS_W-1:0] msg_rounds;
      logic [ROUNDS_W-1:0] fin_rounds;
   } status_type;

   function automatic logic [WORD_W-1:0] rotl(input logic [WORD_W-1:0] x,
                                              input int unsigned s);
      return (x << s) | (x >> (WORD_W - s));
   endfunction

   function automatic lanes_type sip_round(input lanes_type v);
      lanes_type r;
      r = v;
      r[0] = r[0] + r[1]; r[1] = rotl(r[1], 13) ^ r[0]; r[0] = rotl(r[0], 32);
      r[2] = r[2] + r[3]; r[3] = rotl(r[3], 16) ^ r[2];
      r[2] = r[2] + r[1]; r[1] = rotl(r[1], 17) ^ r[2]; r[2] = rotl(r[2], 32);
      r[0] = r[0] + r[3]; r[3] = rotl(r[3], 21) ^ r[0];
      return r;
   endfunction

   // keep the low n bytes
   function automatic logic [WORD_W-1:0] byte_mask(input logic [COUNT_W-1:0] n);
      logic [WORD_W-1:0] m;
      m = '0;
      for (int i = 0; i < BYTES; i++) begin
         if (i < int'(n)) m[8*i +: 8] = 8'hFF;
      end
      return m;
   endfunction

endpackage

// File: sv/sph_if.sv
`timescale 1ns / 1ps

interface sph_req_if;
   import sph_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   data_word;
   logic [COUNT_W-1:0]  byte_count;
   logic                last_word;
   modport source (output valid, data_word, byte_count, last_word, input ready);
   modport sink   (input valid, data_word, byte_count, last_word, output ready);
endinterface

interface sph_rsp_if;
   import sph_pkg::*;
   logic                valid;
   logic                ready;
   logic [WORD_W-1:0]   digest_low;
   logic [WORD_W-1:0]   digest_high;
   modport source (output valid, digest_low, digest_high, input ready);
   modport sink   (input valid, digest_low, digest_high, output ready);
endinterface

interface sph_csr_if;
   import sph_pkg::*;
   logic                valid;
   logic                ready;
   logic [INDEX_W-1:0]  index;
   logic [WORD_W-1:0]   data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/sph_ctrl.sv
`timescale 1ns / 1ps

module sph_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  sph_pkg::status_type  status,
   output sph_pkg::cmd_type     cmd
);
   import sph_pkg::*;

   typedef enum logic [6:0] {
      ST_IDLE    = 7'b0000001,
      ST_INJECT  = 7'b0000010,
      ST_ROUND   = 7'b0000100,
      ST_FOLD    = 7'b0001000,
      ST_FROUND  = 7'b0010000,
      ST_CAPTURE = 7'b0100000,
      ST_EMIT    = 7'b1000000
   } state_type;

   state_type           state_ff, state_in;
   logic [ROUNDS_W-1:0] cnt_ff, cnt_in;
   logic                second_ff, second_in;   // length-only word under way
   logic                phase_ff, phase_in;     // second digest word under way

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      second_in = second_ff;
      phase_in  = phase_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               second_in   = 1'b0;
               state_in    = ST_INJECT;
            end
         end
         ST_INJECT: begin
            cmd.inject   = 1'b1;
            cmd.len_word = second_ff;
            if (status.msg_rounds == '0) begin
               state_in = ST_FOLD;
            end else begin
               cnt_in   = status.msg_rounds;
               state_in = ST_ROUND;
            end
         end
         ST_ROUND: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == ROUNDS_W'(1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            if (!status.last) begin
               state_in = ST_IDLE;
            end else if (status.full && !second_ff) begin
               second_in = 1'b1;
               state_in  = ST_INJECT;
            end else begin
               cmd.fin_tweak = 1'b1;
               phase_in      = 1'b0;
               if (status.fin_rounds == '0) begin
                  state_in = ST_CAPTURE;
               end else begin
                  cnt_in   = status.fin_rounds;
                  state_in = ST_FROUND;
               end
            end
         end
         ST_FROUND: begin
            cmd.round = 1'b1;
            cnt_in    = cnt_ff - 1'b1;
            if (cnt_ff == ROUNDS_W'(1)) state_in = ST_CAPTURE;
         end
         ST_CAPTURE: begin
            if (!phase_ff) begin
               cmd.cap_lo = 1'b1;
               if (status.wide) begin
                  cmd.hi_tweak = 1'b1;
                  phase_in     = 1'b1;
                  if (status.fin_rounds == '0) begin
                     state_in = ST_CAPTURE;
                  end else begin
                     cnt_in   = status.fin_rounds;
                     state_in = ST_FROUND;
                  end
               end else begin
                  state_in = ST_EMIT;
               end
            end else begin
               cmd.cap_hi = 1'b1;
               state_in   = ST_EMIT;
            end
         end
         ST_EMIT: begin
            if (!status.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         cnt_ff    <= '0;
         second_ff <= 1'b0;
         phase_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         cnt_ff    <= cnt_in;
         second_ff <= second_in;
         phase_ff  <= phase_in;
      end
   end

   a_round_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROUND || state_ff == ST_FROUND) |-> cnt_ff != '0)
      else $error("round state entered with an empty round count");

   a_capture_next: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> state_ff == ST_INJECT)
      else $error("accepted word not followed by injection");

   a_len_word: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_INJECT && second_ff) |-> (status.last && status.full))
      else $error("length-only word outside a full last word");

endmodule

// File: sv/sph_datapath.sv
`timescale 1ns / 1ps

module sph_datapath (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [sph_pkg::WORD_W-1:0]    req_data_word,
   input  logic [sph_pkg::COUNT_W-1:0]   req_byte_count,
   input  logic                          req_last_word,
   input  sph_pkg::cmd_type              cmd,
   output sph_pkg::status_type           status,
   sph_rsp_if.source                     rsp_if,
   sph_csr_if.sink                       csr_if
);
   import sph_pkg::*;

   // configuration
   logic [WORD_W-1:0]   key_lo_ff, key_hi_ff;
   logic [ROUNDS_W-1:0] mrounds_ff, frounds_ff;
   logic                wide_ff;

   // working state
   lanes_type           lanes_ff, lanes_in;
   logic [WORD_W-1:0]   word_ff, word_in;
   logic [WORD_W-1:0]   data_ff;
   logic [COUNT_W-1:0]  count_ff;
   logic                last_ff;
   logic [LEN_W-1:0]    len_ff, len_in;
   logic                in_msg_ff, in_msg_in;
   logic [WORD_W-1:0]   dig_lo_ff, dig_hi_ff;

   // output register
   logic                rsp_valid_ff;
   logic [WORD_W-1:0]   rsp_low_ff, rsp_high_ff;

   lanes_type           init_lanes;
   lanes_type           base_lanes;
   logic [LEN_W-1:0]    base_len, new_len;
   logic [WORD_W-1:0]   lanes_xor;

   assign csr_if.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_lo_ff  <= '0;
         key_hi_ff  <= '0;
         mrounds_ff <= ROUNDS_W'(2);
         frounds_ff <= ROUNDS_W'(4);
         wide_ff    <= 1'b0;
      end else if (csr_if.valid) begin
         case (csr_if.index)
            REG_KEY_LOW:         key_lo_ff  <= csr_if.data;
            REG_KEY_HIGH:        key_hi_ff  <= csr_if.data;
            REG_MESSAGE_ROUNDS:  mrounds_ff <= csr_if.data[ROUNDS_W-1:0];
            REG_FINALIZE_ROUNDS: frounds_ff <= csr_if.data[ROUNDS_W-1:0];
            REG_WIDE_OUTPUT:     wide_ff    <= csr_if.data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      init_lanes[0] = SIP_C0 ^ key_lo_ff;
      init_lanes[1] = SIP_C1 ^ key_hi_ff ^ (wide_ff ? WORD_W'(TWEAK_WIDE) : '0);
      init_lanes[2] = SIP_C2 ^ key_lo_ff;
      init_lanes[3] = SIP_C3 ^ key_hi_ff;
      base_lanes    = in_msg_ff ? lanes_ff : init_lanes;
      base_len      = in_msg_ff ? len_ff : '0;
      new_len       = base_len + (last_ff ? LEN_W'(count_ff) : FULL_LEN);
      lanes_xor     = lanes_ff[0] ^ lanes_ff[1] ^ lanes_ff[2] ^ lanes_ff[3];
   end

   always_comb begin
      lanes_in  = lanes_ff;
      word_in   = word_ff;
      len_in    = len_ff;
      in_msg_in = in_msg_ff;
      if (cmd.inject) begin
         in_msg_in = 1'b1;
         if (cmd.len_word) begin
            word_in = {base_len, {(WORD_W-LEN_W){1'b0}}};
         end else begin
            len_in = new_len;
            if (!last_ff || count_ff == FULL_COUNT) begin
               word_in = data_ff;
            end else begin
               word_in = (data_ff & byte_mask(count_ff))
                       | {new_len, {(WORD_W-LEN_W){1'b0}}};
            end
         end
         lanes_in    = base_lanes;
         lanes_in[3] = base_lanes[3] ^ word_in;
      end
      if (cmd.round) lanes_in = sip_round(lanes_ff);
      if (cmd.fold) begin
         lanes_in[0] = lanes_ff[0] ^ word_ff;
         if (cmd.fin_tweak) begin
            lanes_in[2] = lanes_ff[2]
                        ^ WORD_W'(wide_ff ? TWEAK_WIDE : TWEAK_NARROW);
         end
      end
      if (cmd.hi_tweak) lanes_in[1] = lanes_ff[1] ^ WORD_W'(TWEAK_SECOND);
      if (cmd.emit) in_msg_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_msg_ff <= 1'b0;
         len_ff    <= '0;
      end else begin
         in_msg_ff <= in_msg_in;
         len_ff    <= len_in;
      end
   end

   always_ff @(posedge clock) begin
      lanes_ff <= lanes_in;
      word_ff  <= word_in;
      if (cmd.capture) begin
         data_ff  <= req_data_word;
         count_ff <= (req_byte_count > FULL_COUNT) ? FULL_COUNT : req_byte_count;
         last_ff  <= req_last_word;
      end
      if (cmd.cap_lo) begin
         dig_lo_ff <= lanes_xor;
         dig_hi_ff <= '0;
      end
      if (cmd.cap_hi) dig_hi_ff <= lanes_xor;
      if (cmd.emit) begin
         rsp_low_ff  <= dig_lo_ff;
         rsp_high_ff <= dig_hi_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.digest_low  = rsp_low_ff;
   assign rsp_if.digest_high = rsp_high_ff;

   assign status.last       = last_ff;
   assign status.full       = (count_ff == FULL_COUNT);
   assign status.wide       = wide_ff;
   assign status.rsp_busy   = rsp_valid_ff && !rsp_if.ready;
   assign status.msg_rounds = mrounds_ff;
   assign status.fin_rounds = frounds_ff;

   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(cmd.emit))
      else $error("digest raised without an emit");

   a_emit_closes: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |=> !in_msg_ff)
      else $error("message still open after emit");

endmodule

// File: sv/siphash_keyed_hash_core.sv
`timescale 1ns / 1ps

// Keyed SipHash-c-d (SipHash-2-4 at reset) over a message streamed as
// 64-bit little-endian words on req_if; one digest appears on rsp_if
// for each word flagged last_word. Words before the last count as eight
// bytes; the last carries 0 to 8 valid bytes (larger counts saturate to 8).
// Write key_low, key_high, message_rounds, finalize_rounds and wide_output
// through csr_if (index 0 to 4) only while no message is open. A single
// SipRound unit does all mixing, one round per clock. Each word is
// captured, xored into lane 3, mixed by the message rounds and xored
// into lane 0 before the next is taken; a full last word then adds a
// length-only word. Then come the lane 2 tweak, the finalisation rounds
// and the first digest half, in 128-bit mode the lane 1 tweak, the
// rounds again and the second half, and the load of the output
// register, which holds a finished digest while the core takes the next
// message. That load waits only while the previous digest is not taken.

module siphash_keyed_hash_core (
   input  logic       clock,
   input  logic       reset,
   sph_req_if.sink    req_if,
   sph_rsp_if.source  rsp_if,
   sph_csr_if.sink    csr_if
);
   import sph_pkg::*;

   cmd_type    cmd;
   status_type status;

   // sequence the absorb, round and finalise steps
   sph_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // hold the lanes, the length byte, configuration and the output register
   sph_datapath u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_data_word  (req_if.data_word),
      .req_byte_count (req_if.byte_count),
      .req_last_word  (req_if.last_word),
      .cmd            (cmd),
      .status         (status),
      .rsp_if         (rsp_if),
      .csr_if         (csr_if)
   );

endmodule

// File: tb/tb_siphash_keyed_hash_core.sv
`timescale 1ns / 1ps

module tb_siphash_keyed_hash_core;
   import sph_pkg::*;

   // Pacing of both channels: chance in a hundred of idling a cycle.
   localparam int IDLE_PCT        = 38;
   // Cycles to let pass once the last digest is in, before a write or the end.
   // This covers a full last word in 128-bit mode at the largest round counts.
   localparam int DRAIN_CYCLES    = 80;
   localparam int PHASES          = 12;
   localparam int WORDS_PER_PHASE = 115;
   // Long receiver hold-off, started once this many digests have arrived.
   localparam int HOLD_AT         = 40;
   localparam int HOLD_CYCLES     = 400;
   localparam int MAX_SHOWN       = 10;
   localparam longint TIMEOUT_NS  = 64'd8_000_000;

   // Indexes with no register behind them; writes there must change nothing.
   localparam int REG_COUNT = 5;
   localparam logic [INDEX_W-1:0] REG_SPARE     = INDEX_W'(REG_COUNT);
   localparam logic [INDEX_W-1:0] REG_TOP_INDEX = '1;

   typedef struct packed {
      logic [WORD_W-1:0] low;
      logic [WORD_W-1:0] high;
   } digest_type;

   typedef enum bit {ROW_WORD, ROW_CSR} row_kind_type;

   // One row of the directed table: either a register write or a message word.
   // Word rows ignore the index; register rows ignore count, last and digest.
   typedef struct packed {
      row_kind_type        kind;
      logic [INDEX_W-1:0]  index;
      logic [WORD_W-1:0]   value;
      logic [COUNT_W-1:0]  count;
      logic                last;
      bit                  typed;
      logic [WORD_W-1:0]   exp_low;
      logic [WORD_W-1:0]   exp_high;
   } stim_row_type;

   localparam int DIR_LEN = 30;
   localparam stim_row_type DIR_ROWS [DIR_LEN] = '{
      // empty message straight after reset: zero key, 2/4 rounds, 64-bit digest
      '{ROW_WORD, REG_KEY_LOW,         64'h0,                4'd0,  1'b1, 1'b0, 64'h0, 64'h0},
      // load the key 00..0f of the published test vectors
      '{ROW_CSR,  REG_KEY_LOW,         64'h0706050403020100, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_CSR,  REG_KEY_HIGH,        64'h0f0e0d0c0b0a0908, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      // empty message, known digest
      '{ROW_WORD, REG_KEY_LOW,         64'h0,                4'd0,  1'b1, 1'b1,
        64'h726fdb47dd0e0e31, 64'h0},
      // fifteen bytes 00..0e: a short count on a non-last word counts as full,
      // and junk above the valid bytes of the last word must be dropped
      '{ROW_WORD, REG_KEY_LOW,         64'h0706050403020100, 4'd3,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'haa0e0d0c0b0a0908, 4'd7,  1'b1, 1'b1,
        64'ha129ca6149be45e5, 64'h0},
      // full last word: data word, then a length-only word
      '{ROW_WORD, REG_KEY_LOW,         64'hffffffffffffffff, 4'd8,  1'b1, 1'b0, 64'h0, 64'h0},
      // counts above eight saturate
      '{ROW_WORD, REG_KEY_LOW,         64'h0,                4'd15, 1'b1, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'hffffffffffffffff, 4'd9,  1'b1, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'h8000000000000001, 4'd1,  1'b1, 1'b0, 64'h0, 64'h0},
      // 128-bit digest; only bit 0 of the written value counts
      '{ROW_CSR,  REG_WIDE_OUTPUT,     64'hffffffffffffffff, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'h0,                4'd0,  1'b1, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'h0123456789abcdef, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'hfedcba9876543210, 4'd5,  1'b1, 1'b0, 64'h0, 64'h0},
      // one round of each kind
      '{ROW_CSR,  REG_MESSAGE_ROUNDS,  64'h1,                4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_CSR,  REG_FINALIZE_ROUNDS, 64'h1,                4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'h5555555555555555, 4'd8,  1'b1, 1'b0, 64'h0, 64'h0},
      // eight rounds of each kind
      '{ROW_CSR,  REG_MESSAGE_ROUNDS,  64'h8,                4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_CSR,  REG_FINALIZE_ROUNDS, 64'h8,                4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'haaaaaaaaaaaaaaaa, 4'd8,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'h0f0f0f0f0f0f0f0f, 4'd4,  1'b1, 1'b0, 64'h0, 64'h0},
      // zero rounds: no mixing at all
      '{ROW_CSR,  REG_MESSAGE_ROUNDS,  64'h0,                4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_CSR,  REG_FINALIZE_ROUNDS, 64'h0,                4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'h00ff00ff00ff00ff, 4'd6,  1'b1, 1'b0, 64'h0, 64'h0},
      // all-ones round counts, back to a 64-bit digest with junk in the upper bits
      '{ROW_CSR,  REG_MESSAGE_ROUNDS,  64'hfffffffffffffff0 | 64'hf,
        4'd0, 1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_CSR,  REG_FINALIZE_ROUNDS, 64'hf,                4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_CSR,  REG_WIDE_OUTPUT,     64'hfffffffffffffffe, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'hffffffffffffffff, 4'd8,  1'b1, 1'b0, 64'h0, 64'h0},
      // write to an index with no register behind it
      '{ROW_CSR,  REG_SPARE,           64'hffffffffffffffff, 4'd0,  1'b0, 1'b0, 64'h0, 64'h0},
      '{ROW_WORD, REG_KEY_LOW,         64'h3c3c3c3c3c3c3c3c, 4'd2,  1'b1, 1'b0, 64'h0, 64'h0}
   };

   logic clock = 1'b0;
   logic reset;

   sph_req_if u_req ();
   sph_rsp_if u_rsp ();
   sph_csr_if u_csr ();

   siphash_keyed_hash_core u_dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (u_req),
      .rsp_if (u_rsp),
      .csr_if (u_csr)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Digest predictor: own copy of the settings and the hash state
   // ------------------------------------------------------------------
   logic [WORD_W-1:0]   cfg_key_low;
   logic [WORD_W-1:0]   cfg_key_high;
   logic [ROUNDS_W-1:0] cfg_msg_rounds;
   logic [ROUNDS_W-1:0] cfg_fin_rounds;
   logic                cfg_wide;

   logic [WORD_W-1:0]   lane [LANES];
   logic [LEN_W-1:0]    msg_len;
   bit                  msg_open;

   digest_type digest_q [$];   // digests owed by the block, oldest first
   digest_type head;
   int      mismatches;
   int      digests_seen;
   bit      steady;         // set: neither side idles

   function automatic logic [WORD_W-1:0] rol(input logic [WORD_W-1:0] x, input int s);
      logic [2*WORD_W-1:0] t;
      t = {x, x} << s;
      return t[2*WORD_W-1:WORD_W];
   endfunction

   function automatic logic [WORD_W-1:0] lanes_folded();
      return lane[0] ^ lane[1] ^ lane[2] ^ lane[3];
   endfunction

   // Apply n SipRounds to the lanes; a count of zero leaves them alone.
   task automatic sip_mix(input logic [ROUNDS_W-1:0] n);
      for (int r = 0; r < int'(n); r++) begin
         lane[0] = lane[0] + lane[1];
         lane[1] = rol(lane[1], 13) ^ lane[0];
         lane[0] = rol(lane[0], 32);
         lane[2] = lane[2] + lane[3];
         lane[3] = rol(lane[3], 16) ^ lane[2];
         lane[2] = lane[2] + lane[1];
         lane[1] = rol(lane[1], 17) ^ lane[2];
         lane[2] = rol(lane[2], 32);
         lane[0] = lane[0] + lane[3];
         lane[3] = rol(lane[3], 21) ^ lane[0];
      end
   endtask

   task automatic fold_in(input logic [WORD_W-1:0] m);
      lane[3] = lane[3] ^ m;
      sip_mix(cfg_msg_rounds);
      lane[0] = lane[0] ^ m;
   endtask

   // Advance the hash by one accepted word; raise done with the digest
   // when the word closes the message.
   task automatic hash_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] count,
                            input logic last, output bit done, output digest_type d);
      logic [COUNT_W-1:0] n;
      logic [WORD_W-1:0]  len_word;
      n = (count > FULL_COUNT) ? FULL_COUNT : count;
      done = 1'b0;
      d.low = '0;
      d.high = '0;
      // first word of a message: load the lanes from the key
      if (!msg_open) begin
         lane[0] = SIP_C0 ^ cfg_key_low;
         lane[1] = SIP_C1 ^ cfg_key_high;
         lane[2] = SIP_C2 ^ cfg_key_low;
         lane[3] = SIP_C3 ^ cfg_key_high;
         if (cfg_wide) lane[1] = lane[1] ^ WORD_W'(TWEAK_WIDE);
         msg_len = '0;
         msg_open = 1'b1;
      end
      if (!last) begin
         // anything before the last word is a full eight bytes
         fold_in(data);
         msg_len = msg_len + FULL_LEN;
      end else begin
         msg_len = msg_len + LEN_W'(n);
         len_word = {msg_len, {(WORD_W-LEN_W){1'b0}}};
         if (n == FULL_COUNT) begin
            // full last word: the length goes in a word of its own
            fold_in(data);
            fold_in(len_word);
         end else begin
            fold_in((data & ((WORD_W'(1) << (8 * int'(n))) - 1)) | len_word);
         end
         lane[2] = lane[2] ^ (cfg_wide ? WORD_W'(TWEAK_WIDE) : WORD_W'(TWEAK_NARROW));
         sip_mix(cfg_fin_rounds);
         d.low = lanes_folded();
         if (cfg_wide) begin
            lane[1] = lane[1] ^ WORD_W'(TWEAK_SECOND);
            sip_mix(cfg_fin_rounds);
            d.high = lanes_folded();
         end
         msg_open = 1'b0;
         done = 1'b1;
      end
   endtask

   task automatic apply_setting(input logic [INDEX_W-1:0] index, input logic [WORD_W-1:0] value);
      case (csr_reg_type'(index))
         REG_KEY_LOW:         cfg_key_low = value;
         REG_KEY_HIGH:        cfg_key_high = value;
         REG_MESSAGE_ROUNDS:  cfg_msg_rounds = value[ROUNDS_W-1:0];
         REG_FINALIZE_ROUNDS: cfg_fin_rounds = value[ROUNDS_W-1:0];
         REG_WIDE_OUTPUT:     cfg_wide = value[0];
         default: ;
      endcase
   endtask

   // ------------------------------------------------------------------
   // Drivers
   // ------------------------------------------------------------------

   // Drop the request valid, wait for every owed digest, then let the core
   // run dry.
   task automatic wait_idle();
      u_req.valid <= 1'b0;
      while (digest_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [INDEX_W-1:0] index, input logic [WORD_W-1:0] value);
      wait_idle();
      u_csr.valid <= 1'b1;
      u_csr.index <= index;
      u_csr.data  <= value;
      @(posedge clock);
      while (!u_csr.ready) @(posedge clock);
      apply_setting(index, value);
      u_csr.valid <= 1'b0;
   endtask

   // Offer one word and hold it until taken. Valid stays high from one word
   // to the next unless this side idles first.
   task automatic send_word(input logic [WORD_W-1:0] data, input logic [COUNT_W-1:0] count,
                            input logic last, input bit typed, input digest_type typed_digest);
      bit         done;
      digest_type d;
      while (!steady && $urandom_range(99) < IDLE_PCT) begin
         u_req.valid <= 1'b0;
         @(posedge clock);
      end
      u_req.valid      <= 1'b1;
      u_req.data_word  <= data;
      u_req.byte_count <= count;
      u_req.last_word  <= last;
      @(posedge clock);
      while (!u_req.ready) @(posedge clock);
      hash_word(data, count, last, done, d);
      if (done) digest_q.push_back(typed ? typed_digest : d);
   endtask

   // ------------------------------------------------------------------
   // Receiver: random back-pressure, one long hold-off while words keep coming
   // ------------------------------------------------------------------
   initial begin : rsp_pacing
      int hold_left;
      bit hold_done;
      hold_left = 0;
      hold_done = 1'b0;
      u_rsp.ready <= 1'b0;
      forever begin
         @(posedge clock);
         // start the hold-off only while the sender is offering words
         if (!hold_done && digests_seen >= HOLD_AT && u_req.valid) begin
            hold_done = 1'b1;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            u_rsp.ready <= 1'b0;
         end else begin
            u_rsp.ready <= steady || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // ------------------------------------------------------------------
   // Checker: every digest word against the oldest one owed
   // ------------------------------------------------------------------
   task automatic report_mismatch(input string what, input logic [WORD_W-1:0] want_v,
                                  input logic [WORD_W-1:0] got_v);
      mismatches++;
      if (mismatches <= MAX_SHOWN)
         $display("mismatch on %s at %0t: expected %h, got %h", what, $realtime, want_v, got_v);
   endtask

   always @(posedge clock) begin
      if (!reset && u_rsp.valid && u_rsp.ready) begin
         digests_seen <= digests_seen + 1;
         if (digest_q.size() == 0) begin
            report_mismatch("digest with none owed", '0, u_rsp.digest_low);
         end else begin
            head = digest_q.pop_front();
            if (u_rsp.digest_low !== head.low)
               report_mismatch("digest_low", head.low, u_rsp.digest_low);
            if (u_rsp.digest_high !== head.high)
               report_mismatch("digest_high", head.high, u_rsp.digest_high);
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus
   // ------------------------------------------------------------------
   initial begin : stimulus
      digest_type          no_digest;
      digest_type          typed_d;
      int                  sent;
      int                  msg_words;
      int                  pick;
      logic [WORD_W-1:0]   data;
      logic [WORD_W-1:0]   junk;
      logic [COUNT_W-1:0]  count;
      logic [ROUNDS_W-1:0] rounds;

      no_digest.low  = '0;
      no_digest.high = '0;
      mismatches   = 0;
      digests_seen = 0;
      steady       = 1'b0;
      msg_open     = 1'b0;
      msg_len      = '0;
      for (int i = 0; i < LANES; i++) lane[i] = '0;
      cfg_key_low    = '0;
      cfg_key_high   = '0;
      cfg_msg_rounds = ROUNDS_W'(2);
      cfg_fin_rounds = ROUNDS_W'(4);
      cfg_wide       = 1'b0;

      // hold every input at a known value from time zero
      reset            <= 1'b1;
      u_req.valid      <= 1'b0;
      u_req.data_word  <= '0;
      u_req.byte_count <= '0;
      u_req.last_word  <= 1'b0;
      u_csr.valid      <= 1'b0;
      u_csr.index      <= '0;
      u_csr.data       <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed table: extremes, special cases, the published vectors
      for (int i = 0; i < DIR_LEN; i++) begin
         if (DIR_ROWS[i].kind == ROW_CSR) begin
            csr_write(DIR_ROWS[i].index, DIR_ROWS[i].value);
         end else begin
            typed_d.low  = DIR_ROWS[i].exp_low;
            typed_d.high = DIR_ROWS[i].exp_high;
            send_word(DIR_ROWS[i].value, DIR_ROWS[i].count, DIR_ROWS[i].last,
                      DIR_ROWS[i].typed, typed_d);
         end
      end

      // random phases, each under fresh settings written while idle
      for (int p = 0; p < PHASES; p++) begin
         // no idling anywhere across two whole phases
         steady <= (p == 4 || p == 5);
         csr_write(REG_KEY_LOW, {$urandom, $urandom});
         csr_write(REG_KEY_HIGH, {$urandom, $urandom});
         // first phase at one round, second at eight
         for (int k = 0; k < 2; k++) begin
            if (p == 0) begin
               rounds = ROUNDS_W'(1);
            end else if (p == 1) begin
               rounds = ROUNDS_W'(8);
            end else if ($urandom_range(9) == 0) begin
               rounds = ROUNDS_W'($urandom_range(15));
            end else begin
               rounds = ROUNDS_W'($urandom_range(1, 8));
            end
            junk = {$urandom, $urandom};
            csr_write((k == 0) ? REG_MESSAGE_ROUNDS : REG_FINALIZE_ROUNDS,
                      {junk[WORD_W-1:ROUNDS_W], rounds});
         end
         junk = {$urandom, $urandom};
         csr_write(REG_WIDE_OUTPUT, {junk[WORD_W-1:1], (p < 4) ? p[0] : junk[0]});
         if ($urandom_range(2) == 0)
            csr_write(INDEX_W'($urandom_range(REG_COUNT, REG_TOP_INDEX)), {$urandom, $urandom});

         sent = 0;
         while (sent < WORDS_PER_PHASE) begin
            // mostly short messages, some medium, a few long ones that can wrap the length
            pick = $urandom_range(99);
            if (pick < 80) msg_words = $urandom_range(1, 4);
            else if (pick < 95) msg_words = $urandom_range(5, 12);
            else msg_words = $urandom_range(30, 40);
            for (int w = 1; w <= msg_words; w++) begin
               data = {$urandom, $urandom};
               pick = $urandom_range(19);
               if (pick == 0) data = '0;
               else if (pick == 1) data = '1;
               if (w == msg_words && $urandom_range(3) != 0)
                  count = COUNT_W'($urandom_range(0, 8));
               else
                  count = COUNT_W'($urandom_range(15));
               send_word(data, count, w == msg_words, 1'b0, no_digest);
            end
            sent += msg_words;
         end
      end

      steady <= 1'b0;
      wait_idle();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

   // Backstop: end the run if the handshakes stop moving.
   initial begin
      #(TIMEOUT_NS);
      $display("Test completed with failures");
      $finish;
   end

endmodule
